>>> rtl/core/in_order_reorder_receiver_assert.svh
// ----------------------------------------------------------------------------
// in_order_reorder_receiver_assert
// assertion macros shared by the reorder receiver rtl
// ----------------------------------------------------------------------------
`ifndef IN_ORDER_REORDER_RECEIVER_ASSERT_SVH
`define IN_ORDER_REORDER_RECEIVER_ASSERT_SVH

// same-cycle implication, off during reset
`define IORR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("reorder receiver: same-cycle check failed");

// next-cycle implication, off during reset
`define IORR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("reorder receiver: next-cycle check failed");

`endif

>>> rtl/core/iorr_pkg.sv
// ----------------------------------------------------------------------------
// iorr_pkg
// types and codes shared by the in-order reorder receiver
// ----------------------------------------------------------------------------
`default_nettype none

package iorr_pkg;

	// packet type codes
	localparam logic [1:0] OP_DATA  = 2'd0;
	localparam logic [1:0] OP_ACK   = 2'd1;
	localparam logic [1:0] OP_UNSUP = 2'd2;
	localparam logic [1:0] OP_RSVD  = 2'd3;

	// depth of the command queue between front and back
	localparam int CMDQ_DEPTH = 2;

	// result kinds
	typedef enum logic [2:0] {
		KIND_ACK     = 3'd0,
		KIND_DELIVER = 3'd1,
		KIND_NOTED   = 3'd2,
		KIND_BADTYPE = 3'd3,
		KIND_DROPPED = 3'd4
	} kind_t;

	// packet class decided by the front
	typedef enum logic [2:0] {
		CLS_NOTED,
		CLS_BADTYPE,
		CLS_OLD,
		CLS_DROP,
		CLS_STORE
	} cls_t;

	// back sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ACK,
		BK_DELIVER,
		BK_DROP
	} bk_state_t;

	// classified command
	typedef struct packed {
		cls_t        cls;
		logic [31:0] id;
		logic [31:0] payload;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/iorr_front.sv
// ----------------------------------------------------------------------------
// iorr_front
// input register and packet classification against the delivery point
// ----------------------------------------------------------------------------
`default_nettype none

module iorr_front #(
	parameter int WINDOW = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                accept,
	input  wire  [1:0]                         op,
	input  wire  [31:0]                        pkt_id,
	input  wire  [31:0]                        payload,
	input  wire  [31:0]                        last_delivered,
	input  wire  [$clog2(WINDOW)-1:0]          ld_idx,
	input  wire                                q_full,
	output logic                               q_push,
	output iorr_pkg::cmd_t                     q_cmd,
	output logic [$clog2(WINDOW)-1:0]          q_slot,
	output logic                               occupied
);

	localparam int IDX_W = $clog2(WINDOW);

	logic                 valid_s1;
	logic [1:0]           op_s1;
	logic [31:0]          id_s1;
	logic [31:0]          pay_s1;

	logic [31:0]          diff;
	logic [IDX_W:0]       slot_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op;
			id_s1  <= pkt_id;
			pay_s1 <= payload;
		end
	end

	// distance past the delivery point, and ring slot for in-window ids
	assign diff     = id_s1 - last_delivered;
	assign slot_sum = {1'b0, ld_idx} + diff[IDX_W:0];

	always_comb begin
		q_cmd.id      = id_s1;
		q_cmd.payload = pay_s1;
		q_slot        = (slot_sum >= (IDX_W+1)'(WINDOW)) ?
			IDX_W'(slot_sum - (IDX_W+1)'(WINDOW)) : IDX_W'(slot_sum);
		case (op_s1)
			iorr_pkg::OP_ACK: q_cmd.cls = iorr_pkg::CLS_NOTED;
			iorr_pkg::OP_DATA: begin
				if (id_s1 <= last_delivered)
					q_cmd.cls = iorr_pkg::CLS_OLD;
				else if (diff > 32'(WINDOW))
					q_cmd.cls = iorr_pkg::CLS_DROP;
				else
					q_cmd.cls = iorr_pkg::CLS_STORE;
			end
			default: q_cmd.cls = iorr_pkg::CLS_BADTYPE;
		endcase
	end

	assign q_push   = valid_s1 && !q_full;
	assign occupied = valid_s1;

endmodule

`default_nettype wire

>>> rtl/core/iorr_cmdq.sv
// ----------------------------------------------------------------------------
// iorr_cmdq
// short command queue between classification and execution
// ----------------------------------------------------------------------------
`default_nettype none

module iorr_cmdq #(
	parameter int WINDOW = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                push,
	input  iorr_pkg::cmd_t                     push_cmd,
	input  wire  [$clog2(WINDOW)-1:0]          push_slot,
	input  wire                                pop,
	output iorr_pkg::cmd_t                     head_cmd,
	output logic [$clog2(WINDOW)-1:0]          head_slot,
	output logic                               full,
	output logic                               empty
);

	localparam int IDX_W = $clog2(WINDOW);
	localparam int PTR_W = $clog2(iorr_pkg::CMDQ_DEPTH);
	localparam int CNT_W = $clog2(iorr_pkg::CMDQ_DEPTH + 1);

	iorr_pkg::cmd_t       cmd_q  [iorr_pkg::CMDQ_DEPTH];
	logic [IDX_W-1:0]     slot_q [iorr_pkg::CMDQ_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == CNT_W'(iorr_pkg::CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(iorr_pkg::CMDQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(iorr_pkg::CMDQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			cmd_q[wr_ptr_q]  <= push_cmd;
			slot_q[wr_ptr_q] <= push_slot;
		end
	end

	assign head_cmd  = cmd_q[rd_ptr_q];
	assign head_slot = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> rtl/core/iorr_back.sv
// ----------------------------------------------------------------------------
// iorr_back
// slot ring, delivery sequencer and result register
// ----------------------------------------------------------------------------
`default_nettype none

module iorr_back #(
	parameter int WINDOW = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                q_empty,
	input  iorr_pkg::cmd_t                     q_cmd,
	input  wire  [$clog2(WINDOW)-1:0]          q_slot,
	output logic                               q_pop,
	input  wire                                deliver_enable,
	output logic [31:0]                        last_delivered,
	output logic [$clog2(WINDOW)-1:0]          ld_idx,
	output logic                               idle,
	output logic                               res_stb,
	output logic [2:0]                         kind,
	output logic [31:0]                        out_id,
	output logic [31:0]                        out_payload,
	output logic                               confirmed,
	output logic                               last_of_run
);

	localparam int IDX_W = $clog2(WINDOW);

	iorr_pkg::bk_state_t  state_q, state_d;
	logic [31:0]          ld_q, ld_d;
	logic [IDX_W-1:0]     ld_idx_q, ld_idx_d;
	logic                 hs_q, hs_d;
	logic [31:0]          cur_id_q, cur_id_d;
	logic [WINDOW-1:0]    valid_q;

	logic [31:0]          slot_mem_q [WINDOW];
	logic [31:0]          rd_data_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;

	logic                 set_en;
	logic                 clr_en;
	logic [IDX_W-1:0]     clr_idx;

	logic                 stb_q, stb_d;
	iorr_pkg::kind_t      kind_q, kind_d;
	logic [31:0]          id_q, id_d;
	logic [31:0]          pay_q, pay_d;
	logic                 conf_q, conf_d;
	logic                 last_q, last_d;

	logic [IDX_W-1:0]     nidx;
	logic [IDX_W-1:0]     nnidx;
	logic [31:0]          ld_inc;
	logic                 more;

	// ring increment
	assign nidx   = (ld_idx_q == IDX_W'(WINDOW - 1)) ? '0 : ld_idx_q + 1'b1;
	assign nnidx  = (nidx == IDX_W'(WINDOW - 1)) ? '0 : nidx + 1'b1;
	assign ld_inc = ld_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= iorr_pkg::BK_IDLE;
			ld_q     <= '0;
			ld_idx_q <= '0;
			hs_q     <= 1'b0;
			valid_q  <= '0;
			stb_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			ld_q     <= ld_d;
			ld_idx_q <= ld_idx_d;
			hs_q     <= hs_d;
			stb_q    <= stb_d;
			if (set_en)
				valid_q[q_slot] <= 1'b1;
			if (clr_en)
				valid_q[clr_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cur_id_q <= cur_id_d;
		kind_q   <= kind_d;
		id_q     <= id_d;
		pay_q    <= pay_d;
		conf_q   <= conf_d;
		last_q   <= last_d;
	end

	// payload ring
	always_ff @(posedge clk) begin
		if (wr_en)
			slot_mem_q[q_slot] <= q_cmd.payload;
		rd_data_q <= slot_mem_q[rd_addr];
	end

	always_comb begin
		state_d  = state_q;
		ld_d     = ld_q;
		ld_idx_d = ld_idx_q;
		hs_d     = hs_q;
		cur_id_d = cur_id_q;
		q_pop    = 1'b0;
		wr_en    = 1'b0;
		set_en   = 1'b0;
		clr_en   = 1'b0;
		clr_idx  = nidx;
		rd_addr  = nidx;
		more     = 1'b0;
		stb_d    = 1'b0;
		kind_d   = iorr_pkg::KIND_ACK;
		id_d     = cur_id_q;
		pay_d    = '0;
		conf_d   = hs_q;
		last_d   = 1'b1;
		case (state_q)
			iorr_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop    = 1'b1;
					cur_id_d = q_cmd.id;
					case (q_cmd.cls)
						iorr_pkg::CLS_NOTED: begin
							hs_d   = 1'b1;
							stb_d  = 1'b1;
							kind_d = iorr_pkg::KIND_NOTED;
							id_d   = q_cmd.id;
							conf_d = 1'b1;
						end
						iorr_pkg::CLS_OLD: begin
							stb_d  = 1'b1;
							kind_d = iorr_pkg::KIND_ACK;
							id_d   = q_cmd.id;
						end
						iorr_pkg::CLS_DROP: begin
							stb_d   = 1'b1;
							kind_d  = iorr_pkg::KIND_ACK;
							id_d    = q_cmd.id;
							last_d  = 1'b0;
							state_d = iorr_pkg::BK_DROP;
						end
						iorr_pkg::CLS_STORE: begin
							wr_en   = 1'b1;
							set_en  = 1'b1;
							state_d = iorr_pkg::BK_ACK;
						end
						default: begin
							stb_d  = 1'b1;
							kind_d = iorr_pkg::KIND_BADTYPE;
							id_d   = '0;
						end
					endcase
				end
			end
			iorr_pkg::BK_ACK: begin
				// slot was written last cycle; look at the next one in order
				more    = deliver_enable && (ld_q != '1) && valid_q[nidx];
				stb_d   = 1'b1;
				kind_d  = iorr_pkg::KIND_ACK;
				id_d    = cur_id_q;
				last_d  = !more;
				state_d = more ? iorr_pkg::BK_DELIVER : iorr_pkg::BK_IDLE;
			end
			iorr_pkg::BK_DELIVER: begin
				// rd_data_q holds slot nidx, fetch the one after
				more     = (ld_inc != '1) && valid_q[nnidx];
				rd_addr  = nnidx;
				clr_en   = 1'b1;
				ld_d     = ld_inc;
				ld_idx_d = nidx;
				stb_d    = 1'b1;
				kind_d   = iorr_pkg::KIND_DELIVER;
				id_d     = ld_inc;
				pay_d    = rd_data_q;
				last_d   = !more;
				state_d  = more ? iorr_pkg::BK_DELIVER : iorr_pkg::BK_IDLE;
			end
			iorr_pkg::BK_DROP: begin
				stb_d   = 1'b1;
				kind_d  = iorr_pkg::KIND_DROPPED;
				id_d    = cur_id_q;
				state_d = iorr_pkg::BK_IDLE;
			end
			default: begin
				state_d = iorr_pkg::BK_IDLE;
			end
		endcase
	end

	assign last_delivered = ld_q;
	assign ld_idx         = ld_idx_q;
	assign idle           = (state_q == iorr_pkg::BK_IDLE);
	assign res_stb        = stb_q;
	assign kind           = kind_q;
	assign out_id         = id_q;
	assign out_payload    = pay_q;
	assign confirmed      = conf_q;
	assign last_of_run    = last_q;

endmodule

`default_nettype wire

>>> rtl/core/in_order_reorder_receiver.sv
// ----------------------------------------------------------------------------
// in_order_reorder_receiver
// receive side of a selective-repeat link: ack, reorder, in-order delivery
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             word
// -------   ---------  --------------------  ---------------------------------
// packet    in         start && !busy        op, pkt_id, payload
// result    out        res_stb (one cycle)   kind, out_id, out_payload,
//                                            confirmed, last_of_run
// config    in         cfg_we                cfg_wdata -> deliver_enable
//
// an ack, unsupported or old packet gives one result, a dropped packet an ack and a
// drop result, a stored packet an ack and then k <= WINDOW
// deliveries, one per cycle through the single read port of the payload ring
// first result: input reg, queue, BK_ACK if stored, result reg; rest back to back
// async reset clears control state and all slot valid bits at once; no sweep
// results cannot be stalled; busy holds off new packets while one is in flight
// ----------------------------------------------------------------------------
`default_nettype none

module in_order_reorder_receiver #(
	parameter int WINDOW = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  op,
	input  wire  [31:0] pkt_id,
	input  wire  [31:0] payload,
	input  wire         cfg_we,
	input  wire         cfg_wdata,
	output logic        res_stb,
	output logic [2:0]  kind,
	output logic [31:0] out_id,
	output logic [31:0] out_payload,
	output logic        confirmed,
	output logic        last_of_run
);

	localparam int IDX_W = $clog2(WINDOW);

	// consumer attached flag, comes up enabled
	logic                 deliver_enable_q;

	logic                 accept;
	logic                 front_busy;
	logic                 back_idle;

	// front to queue
	logic                 q_push;
	iorr_pkg::cmd_t       push_cmd;
	logic [IDX_W-1:0]     push_slot;
	logic                 q_full;

	// queue to back
	logic                 q_pop;
	logic                 q_empty;
	iorr_pkg::cmd_t       head_cmd;
	logic [IDX_W-1:0]     head_slot;

	// delivery point fed back for classification
	logic [31:0]          last_delivered;
	logic [IDX_W-1:0]     ld_idx;

	// delivery strobes, for the checks
	logic                 dlv_stb;
	logic                 dlv_more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_enable_q <= 1'b1;
		end else if (cfg_we) begin
			deliver_enable_q <= cfg_wdata;
		end
	end

	// one packet in flight at a time: classification reads the delivery
	// point, which is only final once the previous run has drained
	assign busy   = front_busy || !q_empty || !back_idle;
	assign accept = start && !busy;

	iorr_front #(
		.WINDOW(WINDOW)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.op             (op),
		.pkt_id         (pkt_id),
		.payload        (payload),
		.last_delivered (last_delivered),
		.ld_idx         (ld_idx),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_cmd          (push_cmd),
		.q_slot         (push_slot),
		.occupied       (front_busy)
	);

	iorr_cmdq #(
		.WINDOW(WINDOW)
	) u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.push_slot (push_slot),
		.pop       (q_pop),
		.head_cmd  (head_cmd),
		.head_slot (head_slot),
		.full      (q_full),
		.empty     (q_empty)
	);

	iorr_back #(
		.WINDOW(WINDOW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_cmd          (head_cmd),
		.q_slot         (head_slot),
		.q_pop          (q_pop),
		.deliver_enable (deliver_enable_q),
		.last_delivered (last_delivered),
		.ld_idx         (ld_idx),
		.idle           (back_idle),
		.res_stb        (res_stb),
		.kind           (kind),
		.out_id         (out_id),
		.out_payload    (out_payload),
		.confirmed      (confirmed),
		.last_of_run    (last_of_run)
	);

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
`include "in_order_reorder_receiver_assert.svh"

	assign dlv_stb  = res_stb && (kind == iorr_pkg::KIND_DELIVER);
	assign dlv_more = dlv_stb && !last_of_run;

	// an accepted packet keeps the block busy in the following cycle
	`IORR_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)

	// results of one packet come out without gaps
	`IORR_ASSERT_NEXT(a_run_contiguous, clk, arst_n, res_stb && !last_of_run, res_stb)

	// a delivery run walks ids upward one at a time
	`IORR_ASSERT_NEXT(a_dlv_order, clk, arst_n, dlv_more, dlv_stb && out_id == $past(out_id) + 1'b1)

	// handshake confirmation is sticky
	`IORR_ASSERT_NOW(a_confirmed_sticky, clk, arst_n, 1'b1, !$fell(confirmed))

endmodule

`default_nettype wire

>>> dv/tb_in_order_reorder_receiver.sv
// ----------------------------------------------------------------------------
// tb_in_order_reorder_receiver
// self-checking bench for the reorder receiver: a queue-fed packet driver,
// a result monitor with its own reorder predictor, and phases that change
// deliver_enable while the block is idle
// ----------------------------------------------------------------------------

module tb_in_order_reorder_receiver;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW       = 16;
	localparam int LIMIT_CYCLES = 200000;
	// a stored packet can deliver a run of up to WINDOW ids before it settles
	localparam int SETTLE_END   = 4 + WINDOW + 4;
	localparam int SETTLE_CFG   = 4;
	localparam int MAX_REPORTS  = 10;

	// one packet word waiting to be offered
	typedef struct {
		logic [1:0]  op;
		logic [31:0] id;
		logic [31:0] pay;
	} pkt_t;

	// one result word the block should strobe
	typedef struct {
		iorr_pkg::kind_t kind;
		logic [31:0]     id;
		logic [31:0]     pay;
		logic            conf;
		logic            last;
	} res_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic [1:0]  op          = iorr_pkg::OP_DATA;
	logic [31:0] pkt_id      = '0;
	logic [31:0] payload     = '0;
	logic        cfg_we      = 1'b0;
	logic        cfg_wdata   = 1'b0;
	logic        busy;
	logic        res_stb;
	logic [2:0]  kind;
	logic [31:0] out_id;
	logic [31:0] out_payload;
	logic        confirmed;
	logic        last_of_run;

	// packets still to send, results still owed by the block
	pkt_t pkt_q[$];
	res_t res_q[$];

	// predictor copy of the receiver state
	logic [31:0] rx_last;
	logic        rx_valid [WINDOW];
	logic [31:0] rx_pay   [WINDOW];
	logic        rx_conf;
	logic        rx_en;

	int  n_err     = 0;
	int  n_cyc     = 0;
	int  idle_left = 0;
	bit  idle_ok   = 1'b1;

	in_order_reorder_receiver #(
		.WINDOW(WINDOW)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.pkt_id     (pkt_id),
		.payload    (payload),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.res_stb    (res_stb),
		.kind       (kind),
		.out_id     (out_id),
		.out_payload(out_payload),
		.confirmed  (confirmed),
		.last_of_run(last_of_run)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	function automatic res_t res_word(iorr_pkg::kind_t k, logic [31:0] id,
			logic [31:0] pay);
		res_t r;
		r.kind = k;
		r.id   = id;
		r.pay  = pay;
		r.conf = 1'b0;
		r.last = 1'b0;
		return r;
	endfunction

	// work out every result one accepted packet causes, in strobe order
	function automatic void receive_packet(logic [1:0] p_op, logic [31:0] p_id,
			logic [31:0] p_pay);
		res_t        run[$];
		res_t        r;
		logic [31:0] nxt;
		int          slot;
		if (p_op == iorr_pkg::OP_ACK) begin
			// partner confirmed the handshake
			rx_conf = 1'b1;
			run = {run, res_word(iorr_pkg::KIND_NOTED, p_id, '0)};
		end else if (p_op != iorr_pkg::OP_DATA) begin
			// unsupported packet type, state untouched
			run = {run, res_word(iorr_pkg::KIND_BADTYPE, '0, '0)};
		end else begin
			// every data packet is acked first
			run = {run, res_word(iorr_pkg::KIND_ACK, p_id, '0)};
			if (p_id <= rx_last) begin
				// old or duplicate id, ack only
			end else if ((p_id - rx_last) > 32'(WINDOW)) begin
				// too far ahead of the ring, dropped and flagged
				run = {run, res_word(iorr_pkg::KIND_DROPPED, p_id, '0)};
			end else begin
				// store, overwriting any earlier copy of this id
				slot           = int'(p_id % WINDOW);
				rx_valid[slot] = 1'b1;
				rx_pay[slot]   = p_pay;
				// drain the gap-free run that follows the last delivered id
				if (rx_en) begin
					for (int i = 0; i < WINDOW; i++) begin
						if (rx_last == '1)
							break;
						nxt  = rx_last + 32'd1;
						slot = int'(nxt % WINDOW);
						if (!rx_valid[slot])
							break;
						run = {run, res_word(iorr_pkg::KIND_DELIVER, nxt, rx_pay[slot])};
						rx_valid[slot] = 1'b0;
						rx_last        = nxt;
					end
				end
			end
		end
		// confirmed reflects the flag after the step, last marks the end of the run
		foreach (run[k]) begin
			r      = run[k];
			r.conf = rx_conf;
			r.last = (k == run.size() - 1);
			res_q  = {res_q, r};
		end
	endfunction

	// ------------------------------------------------------------------------
	// driver: offers the head of pkt_q, idles in short random bursts
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		logic fire;
		logic go;
		fire = arst_n && start && !busy;
		if (fire)
			void'(pkt_q.pop_front());
		go = 1'b0;
		if (!arst_n) begin
			go = 1'b0;
		end else if (idle_left > 0) begin
			idle_left--;
		end else if ((fire || !start) && idle_ok && $urandom_range(0, 3) == 0) begin
			// idle burst, never drops a word still on offer
			idle_left = $urandom_range(0, 2);
		end else begin
			go = (pkt_q.size() != 0);
		end
		start <= go;
		if (go) begin
			op      <= pkt_q[0].op;
			pkt_id  <= pkt_q[0].id;
			payload <= pkt_q[0].pay;
		end
	end

	// ------------------------------------------------------------------------
	// monitor: checks each strobed result, then predicts the word accepted now
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			if (res_stb) begin
				if (res_q.size() == 0) begin
					n_err++;
					if (n_err <= MAX_REPORTS)
						$display("unexpected result: kind %0d id %h payload %h conf %b last %b",
							kind, out_id, out_payload, confirmed, last_of_run);
				end else begin
					e = res_q.pop_front();
					if (kind !== e.kind || out_id !== e.id || out_payload !== e.pay ||
							confirmed !== e.conf || last_of_run !== e.last) begin
						n_err++;
						if (n_err <= MAX_REPORTS) begin
							$display("mismatch at cycle %0d", n_cyc);
							$display("  expected kind %0d id %h payload %h conf %b last %b",
								e.kind, e.id, e.pay, e.conf, e.last);
							$display("  actual   kind %0d id %h payload %h conf %b last %b",
								kind, out_id, out_payload, confirmed, last_of_run);
						end
					end
				end
			end
			// the word on the inputs is taken at this edge
			if (start && !busy)
				receive_packet(op, pkt_id, payload);
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cyc++;
		if (n_cyc > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", n_cyc);
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	task automatic queue_pkt(logic [1:0] p_op, logic [31:0] p_id, logic [31:0] p_pay);
		pkt_t p;
		p.op  = p_op;
		p.id  = p_id;
		p.pay = p_pay;
		pkt_q = {pkt_q, p};
	endtask

	// sender pauses until every word is sent and every result is back
	task automatic drain(int settle);
		do
			@(negedge clk);
		while (pkt_q.size() != 0 || res_q.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// write deliver_enable while nothing is in flight
	task automatic write_enable(logic v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		rx_en      = v;
	endtask

	// one random sequence built from the settled predictor state
	task automatic add_sequence(ref int n);
		logic [31:0] base;
		logic [31:0] ids[$];
		logic [31:0] t;
		int          k;
		int          j;
		int          pick;
		base = rx_last;
		pick = $urandom_range(0, 19);
		if (pick < 11) begin
			// in-window run with random arrival order
			k = ($urandom_range(0, 3) == 0) ? WINDOW : $urandom_range(1, WINDOW);
			for (int i = 1; i <= k; i++)
				ids = {ids, base + 32'(i)};
			for (int i = k - 1; i > 0; i--) begin
				j      = $urandom_range(0, i);
				t      = ids[i];
				ids[i] = ids[j];
				ids[j] = t;
			end
			// broken run: one id never arrives
			if (k > 1 && $urandom_range(0, 3) == 0)
				ids.delete($urandom_range(0, k - 1));
			// repeated id, possibly still stored
			if ($urandom_range(0, 3) == 0) begin
				t = ids[$urandom_range(0, ids.size() - 1)];
				ids.insert($urandom_range(0, ids.size()), t);
			end
			foreach (ids[i])
				queue_pkt(iorr_pkg::OP_DATA, ids[i], $urandom);
			n += ids.size();
		end else if (pick < 13) begin
			queue_pkt(iorr_pkg::OP_ACK, $urandom, $urandom);
			n++;
		end else if (pick < 15) begin
			queue_pkt(($urandom_range(0, 1) == 0) ? iorr_pkg::OP_UNSUP : iorr_pkg::OP_RSVD,
				$urandom, $urandom);
			n++;
		end else if (pick < 17) begin
			// old id, at or below the last delivered one
			queue_pkt(iorr_pkg::OP_DATA, $urandom_range(0, base), $urandom);
			n++;
		end else begin
			// beyond the window: just past the edge, a bit further, or anywhere
			case ($urandom_range(0, 2))
				0: t = base + 32'(WINDOW) + 32'd1;
				1: t = base + 32'(WINDOW) + 32'd1 + 32'($urandom_range(0, 1000));
				default: t = $urandom;
			endcase
			queue_pkt(iorr_pkg::OP_DATA, t, $urandom);
			n++;
		end
	endtask

	initial begin
		logic en_plan   [4];
		int   quota_plan[4];
		int   n;
		en_plan    = '{1'b0, 1'b1, 1'b0, 1'b1};
		quota_plan = '{30, 30, 30, 30};

		// predictor reset state
		rx_last = '0;
		rx_conf = 1'b0;
		rx_en   = 1'b1;
		foreach (rx_valid[i]) begin
			rx_valid[i] = 1'b0;
			rx_pay[i]   = '0;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_enable(1'b1);

		// directed: old id, store, overwrite, window edges, delivery run
		queue_pkt(iorr_pkg::OP_DATA, 32'd0, 32'hFFFF_FFFF);
		queue_pkt(iorr_pkg::OP_DATA, 32'd2, 32'hFFFF_FFFF);
		queue_pkt(iorr_pkg::OP_DATA, 32'd2, 32'h5A5A_A5A5);
		queue_pkt(iorr_pkg::OP_DATA, 32'd17, 32'h1234_5678);
		queue_pkt(iorr_pkg::OP_DATA, 32'd16, 32'h0000_0000);
		queue_pkt(iorr_pkg::OP_DATA, 32'd1, 32'h8000_0001);
		// unsupported types, then handshake acks at both id extremes
		queue_pkt(iorr_pkg::OP_UNSUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_pkt(iorr_pkg::OP_RSVD, 32'd0, 32'd0);
		queue_pkt(iorr_pkg::OP_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_pkt(iorr_pkg::OP_ACK, 32'd0, 32'd0);
		// far beyond the window, and a duplicate of a delivered id
		queue_pkt(iorr_pkg::OP_DATA, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
		queue_pkt(iorr_pkg::OP_DATA, 32'd2, 32'hDEAD_BEEF);
		drain(SETTLE_CFG);

		// delivery off: packets are stored and wait
		write_enable(1'b0);
		queue_pkt(iorr_pkg::OP_DATA, 32'd4, 32'h0F0F_0F0F);
		queue_pkt(iorr_pkg::OP_DATA, 32'd3, 32'hF0F0_F0F0);
		drain(SETTLE_CFG);

		// delivery back on: the next new packet releases the held run
		write_enable(1'b1);
		queue_pkt(iorr_pkg::OP_DATA, 32'd5, 32'h7FFF_FFFF);
		queue_pkt(iorr_pkg::OP_DATA, 32'd0, 32'h0000_0001);
		drain(SETTLE_CFG);

		// random phases, alternating deliver_enable, no idling in the last one
		for (int ph = 0; ph < 4; ph++) begin
			write_enable(en_plan[ph]);
			if (ph == 3)
				idle_ok = 1'b0;
			n = 0;
			while (n < quota_plan[ph]) begin
				// refill once everything queued is accepted and predicted
				@(negedge clk);
				while (pkt_q.size() != 0)
					@(negedge clk);
				add_sequence(n);
			end
			drain(ph == 3 ? SETTLE_END : SETTLE_CFG);
		end

		if (n_err == 0 && res_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
